// File: sv/assert_macros.svh
// Assertion macros shared by the light level classifier RTL.
// Every macro samples on clk and is disabled while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: when ante holds, cons must hold too.
`define CHK_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: when ante holds, cons must hold in the next cycle.
`define CHK_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/llac_pkg.sv
// Package for the light level classifier: register indexes, level codes,
// configuration and pipeline control structs. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package llac_pkg;

    localparam int LIMIT_BITS     = 12;
    localparam int MEAN_OUT_BITS  = 12;
    localparam int LEVEL_BITS     = 3;
    localparam int PERCENT_BITS   = 7;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 12;
    localparam int PERCENT_SCALE  = 100;

    // Register indexes on the configuration port
    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_DARK_LIMIT     = 3'd0,
        REG_DIM_LIMIT      = 3'd1,
        REG_MODERATE_LIMIT = 3'd2,
        REG_BRIGHT_LIMIT   = 3'd3,
        REG_RELAY_MODE     = 3'd4
    } cfg_index_t;

    // Light level codes
    typedef enum logic [LEVEL_BITS-1:0] {
        LVL_DARK        = 3'd0,
        LVL_DIM         = 3'd1,
        LVL_MODERATE    = 3'd2,
        LVL_BRIGHT      = 3'd3,
        LVL_VERY_BRIGHT = 3'd4
    } level_t;

    // Reset values: 10/30/60/90 percent of full scale
    localparam logic [LIMIT_BITS-1:0] DARK_LIMIT_RST     = 12'd409;
    localparam logic [LIMIT_BITS-1:0] DIM_LIMIT_RST      = 12'd1228;
    localparam logic [LIMIT_BITS-1:0] MODERATE_LIMIT_RST = 12'd2457;
    localparam logic [LIMIT_BITS-1:0] BRIGHT_LIMIT_RST   = 12'd3685;

    typedef struct packed {
        logic [LIMIT_BITS-1:0] dark_limit;
        logic [LIMIT_BITS-1:0] dim_limit;
        logic [LIMIT_BITS-1:0] moderate_limit;
        logic [LIMIT_BITS-1:0] bright_limit;
        logic                  relay_mode;
    } cfg_t;

    // Per-stage control: occupancy and whether the item refreshes the held values
    typedef struct packed {
        logic valid;
        logic upd;
    } pipe_ctl_t;

endpackage

`default_nettype wire

// File: sv/llac_cfg_regs.sv
// Configuration register file for the light level classifier.
// Depends on llac_pkg (register indexes, cfg_t).
`timescale 1ns / 1ps
`default_nettype none

module llac_cfg_regs (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  wr_en,
    input  wire logic [llac_pkg::CFG_INDEX_BITS-1:0]   wr_index,
    input  wire logic [llac_pkg::CFG_DATA_BITS-1:0]    wr_data,
    output llac_pkg::cfg_t                             cfg
);

    llac_pkg::cfg_t cfg_reg;
    llac_pkg::cfg_t cfg_next;

    // Decode one write transaction; unknown indexes leave everything alone
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (llac_pkg::cfg_index_t'(wr_index))
                llac_pkg::REG_DARK_LIMIT:
                    cfg_next.dark_limit = wr_data[llac_pkg::LIMIT_BITS-1:0];
                llac_pkg::REG_DIM_LIMIT:
                    cfg_next.dim_limit = wr_data[llac_pkg::LIMIT_BITS-1:0];
                llac_pkg::REG_MODERATE_LIMIT:
                    cfg_next.moderate_limit = wr_data[llac_pkg::LIMIT_BITS-1:0];
                llac_pkg::REG_BRIGHT_LIMIT:
                    cfg_next.bright_limit = wr_data[llac_pkg::LIMIT_BITS-1:0];
                llac_pkg::REG_RELAY_MODE:
                    cfg_next.relay_mode = wr_data[0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dark_limit     <= llac_pkg::DARK_LIMIT_RST;
            cfg_reg.dim_limit      <= llac_pkg::DIM_LIMIT_RST;
            cfg_reg.moderate_limit <= llac_pkg::MODERATE_LIMIT_RST;
            cfg_reg.bright_limit   <= llac_pkg::BRIGHT_LIMIT_RST;
            cfg_reg.relay_mode     <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: sv/llac_window.sv
// Input stage: sample ring, running window sum and saturating fill counter.
// Depends on llac_pkg (pipe_ctl_t).
`timescale 1ns / 1ps
`default_nettype none

module llac_window #(
    parameter int WINDOW_DEPTH = 8,
    parameter int MIN_FILL     = 4,
    parameter int SAMPLE_BITS  = 12,
    parameter int SUM_BITS     = 15
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [SAMPLE_BITS-1:0] sample,
    input  wire logic                   down_free,
    output llac_pkg::pipe_ctl_t         a_ctl,
    output logic [SUM_BITS-1:0]         a_sum
);

    localparam int DEPTH_BITS = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_BITS   = $clog2(MIN_FILL + 1);

    logic [SAMPLE_BITS-1:0] ring_reg [WINDOW_DEPTH];
    logic [DEPTH_BITS-1:0]  slot_reg;
    logic [DEPTH_BITS-1:0]  slot_next;
    logic [SUM_BITS-1:0]    sum_reg;
    logic [SUM_BITS-1:0]    sum_next;
    logic [CNT_BITS-1:0]    count_reg;
    logic [CNT_BITS-1:0]    count_next;
    logic                   upd_next;
    logic                   stage_free;
    logic                   accept;
    llac_pkg::pipe_ctl_t    a_ctl_reg;
    logic [SUM_BITS-1:0]    a_sum_reg;

    // Stage hands off when empty or when the next stage takes it
    assign stage_free = !a_ctl_reg.valid || down_free;
    assign in_ready   = stage_free;
    assign accept     = in_valid && stage_free;

    // Running sum: drop the entry being overwritten, add the new sample
    always_comb
    begin
        sum_next = sum_reg - SUM_BITS'(ring_reg[slot_reg]) + SUM_BITS'(sample);
        if (slot_reg == DEPTH_BITS'(WINDOW_DEPTH - 1))
            slot_next = '0;
        else
            slot_next = slot_reg + 1'b1;
        if (count_reg < CNT_BITS'(MIN_FILL))
            count_next = count_reg + 1'b1;
        else
            count_next = count_reg;
        upd_next = (count_next >= CNT_BITS'(MIN_FILL));
    end

    // Ring entries, cleared at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW_DEPTH; i++)
            begin
                ring_reg[i] <= '0;
            end
        end
        else if (accept)
        begin
            ring_reg[slot_reg] <= sample;
        end
    end

    // Window state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg  <= '0;
            sum_reg   <= '0;
            count_reg <= '0;
        end
        else if (accept)
        begin
            slot_reg  <= slot_next;
            sum_reg   <= sum_next;
            count_reg <= count_next;
        end
    end

    // Stage register toward the mean stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_ctl_reg <= '0;
        end
        else if (stage_free)
        begin
            a_ctl_reg.valid <= in_valid;
            a_ctl_reg.upd   <= upd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            a_sum_reg <= sum_next;
    end

    assign a_ctl = a_ctl_reg;
    assign a_sum = a_sum_reg;

endmodule

`default_nettype wire

// File: sv/llac_mean.sv
// Mean stage: window sum divided by the window depth through a reciprocal multiply.
// Depends on llac_pkg (pipe_ctl_t).
`timescale 1ns / 1ps
`default_nettype none

module llac_mean #(
    parameter int WINDOW_DEPTH = 8,
    parameter int SAMPLE_BITS  = 12,
    parameter int SUM_BITS     = 15
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  llac_pkg::pipe_ctl_t       a_ctl,
    input  wire logic [SUM_BITS-1:0]  a_sum,
    input  wire logic                 down_free,
    output logic                      stage_free,
    output llac_pkg::pipe_ctl_t       b_ctl,
    output logic [SAMPLE_BITS-1:0]    b_mean
);

    localparam int DEPTH_BITS = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    // floor(x / D) == (x * ceil(2^K / D)) >> K for every x below 2^SUM_BITS
    localparam int MEAN_SHIFT = SUM_BITS + DEPTH_BITS;
    localparam longint unsigned MEAN_MUL =
        ((64'd1 << MEAN_SHIFT) + WINDOW_DEPTH - 1) / WINDOW_DEPTH;
    localparam int MEAN_MUL_BITS = $clog2(MEAN_MUL + 1);
    localparam int PROD_BITS     = SUM_BITS + MEAN_MUL_BITS;

    logic [PROD_BITS-1:0]   prod;
    llac_pkg::pipe_ctl_t    b_ctl_reg;
    logic [SAMPLE_BITS-1:0] b_mean_reg;

    assign stage_free = !b_ctl_reg.valid || down_free;

    // Reciprocal multiply; the quotient sits above the shift point
    assign prod = PROD_BITS'(a_sum) * PROD_BITS'(MEAN_MUL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_ctl_reg <= '0;
        else if (stage_free)
            b_ctl_reg <= a_ctl;
    end

    always_ff @(posedge clk)
    begin
        if (stage_free && a_ctl.valid)
            b_mean_reg <= prod[MEAN_SHIFT +: SAMPLE_BITS];
    end

    assign b_ctl  = b_ctl_reg;
    assign b_mean = b_mean_reg;

endmodule

`default_nettype wire

// File: sv/llac_classify.sv
// Output stage: level classification, percent scaling, held values and result register.
// Depends on llac_pkg (cfg_t, level_t, pipe_ctl_t, field widths).
`timescale 1ns / 1ps
`default_nettype none

module llac_classify #(
    parameter int SAMPLE_BITS = 12
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  llac_pkg::pipe_ctl_t                       b_ctl,
    input  wire logic [SAMPLE_BITS-1:0]               b_mean,
    input  llac_pkg::cfg_t                            cfg,
    output logic                                      stage_free,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic [llac_pkg::MEAN_OUT_BITS-1:0]        mean_value,
    output logic [llac_pkg::LEVEL_BITS-1:0]           light_level,
    output logic [llac_pkg::PERCENT_BITS-1:0]         light_percent,
    output logic                                      relay_on,
    output logic                                      is_bright,
    output logic                                      updated
);

    localparam int CMP_BITS = (SAMPLE_BITS > llac_pkg::LIMIT_BITS) ?
                              SAMPLE_BITS : llac_pkg::LIMIT_BITS;
    // floor(m * 100 / FS) == (m * ceil(100 * 2^K / FS)) >> K with K = 2 * SAMPLE_BITS
    localparam int PCT_SHIFT = 2 * SAMPLE_BITS;
    localparam longint unsigned FULL_SCALE = (64'd1 << SAMPLE_BITS) - 64'd1;
    localparam longint unsigned PCT_MUL =
        (llac_pkg::PERCENT_SCALE * (64'd1 << PCT_SHIFT) + FULL_SCALE - 64'd1) / FULL_SCALE;
    localparam int PCT_MUL_BITS  = $clog2(PCT_MUL + 1);
    localparam int PCT_PROD_BITS = SAMPLE_BITS + PCT_MUL_BITS;

    logic [CMP_BITS-1:0]                     mean_wide;
    logic [PCT_PROD_BITS-1:0]                pct_prod;
    llac_pkg::level_t                        level_new;
    logic                                    advance;

    logic [llac_pkg::MEAN_OUT_BITS-1:0]      held_mean_reg;
    logic [llac_pkg::MEAN_OUT_BITS-1:0]      held_mean_next;
    llac_pkg::level_t                        held_level_reg;
    llac_pkg::level_t                        held_level_next;
    logic [llac_pkg::PERCENT_BITS-1:0]       held_percent_reg;
    logic [llac_pkg::PERCENT_BITS-1:0]       held_percent_next;
    logic                                    relay_next;
    logic                                    bright_next;

    logic                                    out_valid_reg;
    logic [llac_pkg::MEAN_OUT_BITS-1:0]      mean_value_reg;
    llac_pkg::level_t                        light_level_reg;
    logic [llac_pkg::PERCENT_BITS-1:0]       light_percent_reg;
    logic                                    relay_on_reg;
    logic                                    is_bright_reg;
    logic                                    updated_reg;

    assign stage_free = !out_valid_reg || out_ready;
    assign advance    = b_ctl.valid && stage_free;

    // Level: thresholds checked in order, first match wins
    assign mean_wide = CMP_BITS'(b_mean);

    always_comb
    begin
        priority if (mean_wide <= CMP_BITS'(cfg.dark_limit))
            level_new = llac_pkg::LVL_DARK;
        else if (mean_wide <= CMP_BITS'(cfg.dim_limit))
            level_new = llac_pkg::LVL_DIM;
        else if (mean_wide <= CMP_BITS'(cfg.moderate_limit))
            level_new = llac_pkg::LVL_MODERATE;
        else if (mean_wide <= CMP_BITS'(cfg.bright_limit))
            level_new = llac_pkg::LVL_BRIGHT;
        else
            level_new = llac_pkg::LVL_VERY_BRIGHT;
    end

    // Percent of full scale through a reciprocal multiply
    assign pct_prod = PCT_PROD_BITS'(b_mean) * PCT_PROD_BITS'(PCT_MUL);

    // Held values refresh only once the window has enough samples
    always_comb
    begin
        if (b_ctl.upd)
        begin
            held_mean_next    = mean_wide[llac_pkg::MEAN_OUT_BITS-1:0];
            held_level_next   = level_new;
            held_percent_next = pct_prod[PCT_SHIFT +: llac_pkg::PERCENT_BITS];
        end
        else
        begin
            held_mean_next    = held_mean_reg;
            held_level_next   = held_level_reg;
            held_percent_next = held_percent_reg;
        end
    end

    // Relay and bright flags from the held level under the relay mode
    always_comb
    begin
        if (!cfg.relay_mode)
        begin
            relay_next  = (held_level_next <= llac_pkg::LVL_DIM);
            bright_next = (held_level_next >= llac_pkg::LVL_MODERATE);
        end
        else
        begin
            relay_next  = (held_level_next == llac_pkg::LVL_DARK);
            bright_next = (held_level_next >= llac_pkg::LVL_BRIGHT);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_mean_reg    <= '0;
            held_level_reg   <= llac_pkg::LVL_DARK;
            held_percent_reg <= '0;
        end
        else if (advance)
        begin
            held_mean_reg    <= held_mean_next;
            held_level_reg   <= held_level_next;
            held_percent_reg <= held_percent_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (stage_free)
            out_valid_reg <= b_ctl.valid;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            mean_value_reg    <= held_mean_next;
            light_level_reg   <= held_level_next;
            light_percent_reg <= held_percent_next;
            relay_on_reg      <= relay_next;
            is_bright_reg     <= bright_next;
            updated_reg       <= b_ctl.upd;
        end
    end

    assign out_valid     = out_valid_reg;
    assign mean_value    = mean_value_reg;
    assign light_level   = light_level_reg;
    assign light_percent = light_percent_reg;
    assign relay_on      = relay_on_reg;
    assign is_bright     = is_bright_reg;
    assign updated       = updated_reg;

endmodule

`default_nettype wire

// File: sv/light_level_averaging_classifier_unit.sv
// Result path: each input transaction passes through the window, mean and result registers.
// Throughput: one sample per cycle while out_ready holds; three register stages (window sum, mean
// multiply, classify/percent) each hand off as soon as the next one is free.
// Reset: asynchronous, active low; ring, sum, counter, held values, valid flags
// and config registers return to their defaults at once, with no clearing pass.
// Depends on llac_pkg, assert_macros.svh and the llac_* submodules.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module light_level_averaging_classifier_unit #(
    parameter int WINDOW_DEPTH = 8,
    parameter int MIN_FILL     = 4,
    parameter int SAMPLE_BITS  = 12
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic [SAMPLE_BITS-1:0]               sample,
    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic [llac_pkg::MEAN_OUT_BITS-1:0]        mean_value,
    output logic [llac_pkg::LEVEL_BITS-1:0]           light_level,
    output logic [llac_pkg::PERCENT_BITS-1:0]         light_percent,
    output logic                                      relay_on,
    output logic                                      is_bright,
    output logic                                      updated,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [llac_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [llac_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    localparam int DEPTH_BITS = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int SUM_BITS   = SAMPLE_BITS + DEPTH_BITS;

    llac_pkg::cfg_t         cfg;
    llac_pkg::pipe_ctl_t    a_ctl;
    llac_pkg::pipe_ctl_t    b_ctl;
    logic [SUM_BITS-1:0]    a_sum;
    logic [SAMPLE_BITS-1:0] b_mean;
    logic                   b_free;
    logic                   c_free;

    // Configuration writes are always accepted; cfg_ready is tied high
    assign cfg_ready = 1'b1;

    llac_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    llac_window #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .MIN_FILL     (MIN_FILL),
        .SAMPLE_BITS  (SAMPLE_BITS),
        .SUM_BITS     (SUM_BITS)
    ) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .sample    (sample),
        .down_free (b_free),
        .a_ctl     (a_ctl),
        .a_sum     (a_sum)
    );

    llac_mean #(
        .WINDOW_DEPTH (WINDOW_DEPTH),
        .SAMPLE_BITS  (SAMPLE_BITS),
        .SUM_BITS     (SUM_BITS)
    ) u_mean (
        .clk        (clk),
        .rst_n      (rst_n),
        .a_ctl      (a_ctl),
        .a_sum      (a_sum),
        .down_free  (c_free),
        .stage_free (b_free),
        .b_ctl      (b_ctl),
        .b_mean     (b_mean)
    );

    llac_classify #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_classify (
        .clk           (clk),
        .rst_n         (rst_n),
        .b_ctl         (b_ctl),
        .b_mean        (b_mean),
        .cfg           (cfg),
        .stage_free    (c_free),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .mean_value    (mean_value),
        .light_level   (light_level),
        .light_percent (light_percent),
        .relay_on      (relay_on),
        .is_bright     (is_bright),
        .updated       (updated)
    );

    // Relay and bright flags never claim the same level
    `CHK_SAME(a_flags_exclusive, out_valid, !(relay_on && is_bright), "relay_on and is_bright both set")
    // Percent scaling stays within full scale
    `CHK_SAME(a_percent_range, out_valid, light_percent <= 7'd100, "light_percent above 100")
    // Input backs up only behind a stalled result
    `CHK_SAME(a_ready_only_on_stall, !in_ready, out_valid && !out_ready, "input stalled without output stall")
    // A stalled result carries over to the next cycle
    `CHK_NEXT(a_result_kept, out_valid && !out_ready, out_valid, "pending result dropped")

endmodule

`default_nettype wire

// File: tb/tb_top.sv
// Self-checking bench for light_level_averaging_classifier_unit: random and directed
// light samples, a cycle-free predictor of the window mean, level, percent and relay flags.
// Depends on llac_pkg and the RTL of the unit; no other files.
`timescale 1ns / 1ps

module tb_top;

    localparam int WINDOW       = 8;
    localparam int MIN_FILL     = 4;
    localparam int FULL_SCALE   = 4095;
    localparam int PIPE_LATENCY = 3;

    // Relay mode codes (bit 0 of the relay_mode register)
    localparam logic RELAY_DARK_OR_DIM = 1'b0;
    localparam logic RELAY_DARK_ONLY   = 1'b1;

    // Indexes past the register list; writes there must change nothing
    localparam logic [llac_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_LOW  = 3'd5;
    localparam logic [llac_pkg::CFG_INDEX_BITS-1:0] REG_SPARE_HIGH = 3'd7;

    localparam logic [11:0] ALT_HIGH = 12'hAAA;
    localparam logic [11:0] ALT_LOW  = 12'h555;

    typedef struct {
        logic [11:0] value;
        int          gap;
    } light_sample_t;

    typedef struct {
        logic [llac_pkg::MEAN_OUT_BITS-1:0] mean;
        llac_pkg::level_t                   level;
        logic [llac_pkg::PERCENT_BITS-1:0]  percent;
        logic                               relay;
        logic                               bright;
        logic                               upd;
    } light_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                                 in_valid = 1'b0;
    logic                                 in_ready;
    logic [11:0]                          sample = '0;
    logic                                 out_valid;
    logic                                 out_ready = 1'b0;
    logic [llac_pkg::MEAN_OUT_BITS-1:0]   mean_value;
    logic [llac_pkg::LEVEL_BITS-1:0]      light_level;
    logic [llac_pkg::PERCENT_BITS-1:0]    light_percent;
    logic                                 relay_on;
    logic                                 is_bright;
    logic                                 updated;
    logic                                 cfg_valid = 1'b0;
    logic                                 cfg_ready;
    logic [llac_pkg::CFG_INDEX_BITS-1:0]  cfg_index = '0;
    logic [llac_pkg::CFG_DATA_BITS-1:0]   cfg_data = '0;

    light_level_averaging_classifier_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .sample        (sample),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .mean_value    (mean_value),
        .light_level   (light_level),
        .light_percent (light_percent),
        .relay_on      (relay_on),
        .is_bright     (is_bright),
        .updated       (updated),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // Predictor state: sample window, fill counter, held results, registers
    logic [11:0]                        window_mem [WINDOW];
    logic [2:0]                         window_slot = '0;
    logic [14:0]                        window_sum = '0;
    int                                 fill_count = 0;
    logic [llac_pkg::MEAN_OUT_BITS-1:0] held_mean = '0;
    llac_pkg::level_t                   held_level = llac_pkg::LVL_DARK;
    logic [llac_pkg::PERCENT_BITS-1:0]  held_percent = '0;
    logic [11:0]                        lim_dark = llac_pkg::DARK_LIMIT_RST;
    logic [11:0]                        lim_dim = llac_pkg::DIM_LIMIT_RST;
    logic [11:0]                        lim_moderate = llac_pkg::MODERATE_LIMIT_RST;
    logic [11:0]                        lim_bright = llac_pkg::BRIGHT_LIMIT_RST;
    logic                               relay_mode_q = RELAY_DARK_OR_DIM;

    light_sample_t sample_queue[$];
    light_result_t expected_results[$];

    logic sample_taken = 1'b0;
    logic result_taken = 1'b0;
    int   send_idle_max = 0;
    int   recv_idle_max = 0;
    int   send_wait = 0;
    logic gap_loaded = 1'b0;
    int   recv_wait = 0;
    logic stall_loaded = 1'b0;

    int mismatches = 0;
    int samples_in = 0;
    int results_checked = 0;
    int cfg_write_count = 0;
    int phases_run = 0;
    int level_seen [5] = '{default: 0};

    // Clock
    initial begin
        forever #5 clk = ~clk;
    end

    // Run limit
    initial begin
        #2_000_000;
        $display("Timeout: %0d samples in, %0d results still pending",
                 samples_in, expected_results.size());
        $display("Some tests failed");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [11:0] got,
                               input logic [11:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                      results_checked, name, got, want));
    endtask

    function automatic llac_pkg::level_t grade_level(input logic [11:0] m);
        if (m <= lim_dark)     return llac_pkg::LVL_DARK;
        if (m <= lim_dim)      return llac_pkg::LVL_DIM;
        if (m <= lim_moderate) return llac_pkg::LVL_MODERATE;
        if (m <= lim_bright)   return llac_pkg::LVL_BRIGHT;
        return llac_pkg::LVL_VERY_BRIGHT;
    endfunction

    // Window update and held-result refresh for one accepted sample
    task automatic predict_light(input logic [11:0] s);
        light_result_t r;
        logic [11:0]   m;
        window_sum = window_sum - window_mem[window_slot] + s;
        window_mem[window_slot] = s;
        window_slot = window_slot + 3'd1;
        if (fill_count < MIN_FILL) fill_count++;
        r.upd = 1'b0;
        if (fill_count >= MIN_FILL) begin
            m = 12'(window_sum / WINDOW);
            held_mean = m;
            held_level = grade_level(m);
            held_percent = llac_pkg::PERCENT_BITS'(
                (int'(m) * llac_pkg::PERCENT_SCALE) / FULL_SCALE);
            r.upd = 1'b1;
        end
        if (relay_mode_q == RELAY_DARK_OR_DIM) begin
            r.relay = (held_level <= llac_pkg::LVL_DIM);
            r.bright = (held_level >= llac_pkg::LVL_MODERATE);
        end else begin
            r.relay = (held_level == llac_pkg::LVL_DARK);
            r.bright = (held_level >= llac_pkg::LVL_BRIGHT);
        end
        r.mean = held_mean;
        r.level = held_level;
        r.percent = held_percent;
        expected_results.push_back(r);
    endtask

    // Input side: record accepted transactions and predict their results
    always @(posedge clk) begin : take_samples
        sample_taken <= in_valid && in_ready;
        if (in_valid && in_ready) begin
            predict_light(sample);
            samples_in++;
        end
    end

    // Register writes take effect in the predictor on acceptance
    always @(posedge clk) begin : take_cfg
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                llac_pkg::REG_DARK_LIMIT:     lim_dark = cfg_data;
                llac_pkg::REG_DIM_LIMIT:      lim_dim = cfg_data;
                llac_pkg::REG_MODERATE_LIMIT: lim_moderate = cfg_data;
                llac_pkg::REG_BRIGHT_LIMIT:   lim_bright = cfg_data;
                llac_pkg::REG_RELAY_MODE:     relay_mode_q = cfg_data[0];
                default:                      ;
            endcase
            cfg_write_count <= cfg_write_count + 1;
        end
    end

    // Sample driver: each queued item waits out its gap, then valid holds until taken
    always @(negedge clk) begin : drive_samples
        logic          nv;
        logic [11:0]   ns;
        light_sample_t it;
        nv = in_valid;
        ns = sample;
        if (!in_valid || sample_taken) begin
            nv = 1'b0;
            if (sample_queue.size() > 0) begin
                if (!gap_loaded) begin
                    send_wait = sample_queue[0].gap;
                    gap_loaded = 1'b1;
                end
                if (send_wait == 0) begin
                    it = sample_queue.pop_front();
                    nv = 1'b1;
                    ns = it.value;
                    gap_loaded = 1'b0;
                end else begin
                    send_wait--;
                end
            end
        end
        in_valid <= nv;
        sample <= ns;
    end

    // Result side backpressure: a fresh stall drawn after every result transaction
    always @(negedge clk) begin : drive_out_ready
        if (result_taken || !stall_loaded) begin
            recv_wait = $urandom_range(0, recv_idle_max);
            stall_loaded = 1'b1;
        end
        if (recv_wait > 0) begin
            recv_wait--;
            out_ready <= 1'b0;
        end else begin
            out_ready <= 1'b1;
        end
    end

    // Monitor: compare each result transaction with the oldest prediction
    always @(posedge clk) begin : check_results
        light_result_t want;
        result_taken <= out_valid && out_ready;
        if (rst_n && out_valid && out_ready) begin
            if (expected_results.size() == 0) begin
                report_mismatch($sformatf("unexpected result, mean %0d level %0d",
                                          mean_value, light_level));
            end else begin
                want = expected_results.pop_front();
                check_field("mean_value", mean_value, want.mean);
                check_field("light_level", light_level, want.level);
                check_field("light_percent", light_percent, want.percent);
                check_field("relay_on", relay_on, want.relay);
                check_field("is_bright", is_bright, want.bright);
                check_field("updated", updated, want.upd);
                if (int'(want.level) < 5) level_seen[want.level]++;
                results_checked++;
            end
        end
    end

    task automatic push_sample(input logic [11:0] v);
        light_sample_t it;
        it.value = v;
        it.gap = $urandom_range(0, send_idle_max);
        sample_queue.push_back(it);
    endtask

    function automatic int pick_idle();
        case ($urandom_range(0, 3))
            0, 1:    return 0;
            2:       return 3;
            default: return 8;
        endcase
    endfunction

    // A value at or next to one of the current limits
    function automatic logic [11:0] near_limit();
        int base;
        int v;
        case ($urandom_range(0, 3))
            0:       base = lim_dark;
            1:       base = lim_dim;
            2:       base = lim_moderate;
            default: base = lim_bright;
        endcase
        v = base + $urandom_range(0, 2) - 1;
        if (v < 0) v = 0;
        if (v > FULL_SCALE) v = FULL_SCALE;
        return 12'(v);
    endfunction

    // Random samples in bursts; half the draws start steady runs that settle
    // the mean on or beside a limit, the rest are noise and bit patterns
    task automatic queue_random(input int count);
        int          n;
        int          run_left;
        logic [11:0] run_value;
        int          pick;
        n = 0;
        run_left = 0;
        run_value = '0;
        while (n < count) begin
            if (n % 40 == 0) begin
                do @(posedge clk); while (sample_queue.size() != 0);
                send_idle_max = pick_idle();
                recv_idle_max = pick_idle();
            end
            if (run_left > 0) begin
                push_sample(run_value);
                run_left--;
            end else begin
                pick = $urandom_range(0, 9);
                if (pick < 5) begin
                    run_value = near_limit();
                    run_left = $urandom_range(7, 11);
                    push_sample(run_value);
                end else if (pick == 8) begin
                    case ($urandom_range(0, 3))
                        0:       push_sample(12'd0);
                        1:       push_sample(12'(FULL_SCALE));
                        2:       push_sample(ALT_HIGH);
                        default: push_sample(ALT_LOW);
                    endcase
                end else begin
                    push_sample(12'($urandom_range(0, FULL_SCALE)));
                end
            end
            n++;
        end
    endtask

    // Wait for every sample taken and every result seen, then let the pipe settle
    task automatic wait_idle();
        do @(posedge clk);
        while (sample_queue.size() != 0 || in_valid || expected_results.size() != 0);
        repeat (PIPE_LATENCY + 2) @(negedge clk);
    endtask

    task automatic write_reg(input logic [llac_pkg::CFG_INDEX_BITS-1:0] idx,
                             input logic [llac_pkg::CFG_DATA_BITS-1:0] data);
        int start;
        start = cfg_write_count;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(negedge clk); while (cfg_write_count == start);
    endtask

    // All five registers, then a write to a spare index that must be ignored
    task automatic program_regs(input logic [11:0] d, input logic [11:0] m1,
                                input logic [11:0] m2, input logic [11:0] b,
                                input logic mode);
        write_reg(llac_pkg::REG_DARK_LIMIT, d);
        write_reg(llac_pkg::REG_DIM_LIMIT, m1);
        write_reg(llac_pkg::REG_MODERATE_LIMIT, m2);
        write_reg(llac_pkg::REG_BRIGHT_LIMIT, b);
        write_reg(llac_pkg::REG_RELAY_MODE, {11'($urandom()), mode});
        write_reg($urandom_range(0, 1) ? REG_SPARE_LOW : REG_SPARE_HIGH,
                  12'($urandom()));
        cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        int a;
        int b;
        int c;
        int d;
        for (int i = 0; i < WINDOW; i++) window_mem[i] = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: partial fill, full scale, zeros, a run sitting on the dark limit
        @(posedge clk);
        push_sample(12'(FULL_SCALE));
        push_sample(12'd0);
        push_sample(12'(FULL_SCALE));
        push_sample(12'(FULL_SCALE));
        repeat (4) push_sample(12'(FULL_SCALE));
        repeat (8) push_sample(12'd0);
        repeat (8) push_sample(llac_pkg::DARK_LIMIT_RST);
        wait_idle();

        // Default registers
        queue_random(250);
        wait_idle();
        phases_run++;

        // Default limits, narrow relay mode
        program_regs(llac_pkg::DARK_LIMIT_RST, llac_pkg::DIM_LIMIT_RST,
                     llac_pkg::MODERATE_LIMIT_RST, llac_pkg::BRIGHT_LIMIT_RST,
                     RELAY_DARK_ONLY);
        queue_random(250);
        wait_idle();
        phases_run++;

        // All limits at zero
        program_regs(12'd0, 12'd0, 12'd0, 12'd0, RELAY_DARK_OR_DIM);
        queue_random(250);
        wait_idle();
        phases_run++;

        // All limits at full scale
        program_regs(12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, RELAY_DARK_ONLY);
        queue_random(250);
        wait_idle();
        phases_run++;

        // Limits out of order: first matching check wins
        program_regs(12'd3000, 12'd1000, 12'd2000, 12'd500, RELAY_DARK_OR_DIM);
        queue_random(250);
        wait_idle();
        phases_run++;

        // Random ascending limits, random mode
        repeat (2) begin
            a = $urandom_range(0, FULL_SCALE);
            b = $urandom_range(a, FULL_SCALE);
            c = $urandom_range(b, FULL_SCALE);
            d = $urandom_range(c, FULL_SCALE);
            program_regs(12'(a), 12'(b), 12'(c), 12'(d), 1'($urandom_range(0, 1)));
            queue_random(250);
            wait_idle();
            phases_run++;
        end

        if (expected_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_results.size()));

        $display("Covered %0d samples, %0d results, %0d register writes over %0d settings",
                 samples_in, results_checked, cfg_write_count, phases_run);
        $display("Levels dark/dim/moderate/bright/very bright: %0d/%0d/%0d/%0d/%0d",
                 level_seen[0], level_seen[1], level_seen[2], level_seen[3], level_seen[4]);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: light_level_averaging_classifier_unit.f
+incdir+sv
sv/llac_pkg.sv
sv/llac_cfg_regs.sv
sv/llac_window.sv
sv/llac_mean.sv
sv/llac_classify.sv
sv/light_level_averaging_classifier_unit.sv
tb/tb_top.sv
